// ----- rtl/core/ook_pulse_bucket_encoder_top_defines.svh -----
// Assertion macros used by the pulse bucket encoder checker.
`ifndef OOK_PULSE_BUCKET_ENCODER_TOP_DEFINES_SVH
`define OOK_PULSE_BUCKET_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define OPBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define OPBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/opbe_pkg.sv -----
// Shared constants, register indexes and control types of the pulse bucket encoder.
package opbe_pkg;

  localparam int TABLE_DEPTH   = 16;
  localparam int MAX_CODE_BITS = 31;

  localparam int UNIT_W   = 16;
  localparam int FACTOR_W = 7;
  localparam int DUR_W    = 23;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = IDX_W + 1;
  localparam int CODE_W   = 31;
  localparam int BITCNT_W = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_UNIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd6;

  localparam logic [UNIT_W-1:0]   RST_PULSE_UNIT = 16'd350;
  localparam logic [FACTOR_W-1:0] RST_SYNC_HIGH  = 7'd1;
  localparam logic [FACTOR_W-1:0] RST_SYNC_LOW   = 7'd31;
  localparam logic [FACTOR_W-1:0] RST_ZERO_HIGH  = 7'd1;
  localparam logic [FACTOR_W-1:0] RST_ZERO_LOW   = 7'd3;
  localparam logic [FACTOR_W-1:0] RST_ONE_HIGH   = 7'd3;
  localparam logic [FACTOR_W-1:0] RST_ONE_LOW    = 7'd1;

  localparam int NUM_PROD = 6;
  localparam int PROD_W   = 3;
  localparam logic [PROD_W-1:0] PROD_SYNC_HIGH = 3'd0;
  localparam logic [PROD_W-1:0] PROD_SYNC_LOW  = 3'd1;
  localparam logic [PROD_W-1:0] PROD_ZERO_HIGH = 3'd2;
  localparam logic [PROD_W-1:0] PROD_ZERO_LOW  = 3'd3;
  localparam logic [PROD_W-1:0] PROD_ONE_HIGH  = 3'd4;
  localparam logic [PROD_W-1:0] PROD_ONE_LOW   = 3'd5;

  localparam logic ACTION_SEND  = 1'b0;
  localparam logic ACTION_CLEAR = 1'b1;

  typedef struct packed {
    logic                load;
    logic                clear;
    logic                prep_en;
    logic [PROD_W-1:0]   prep_idx;
    logic                emit;
    logic                sync;
    logic                high;
    logic                last;
    logic [BITCNT_W-1:0] bit_left;
  } opbe_cmd_t;

  typedef struct packed {
    logic [BITCNT_W-1:0] sat_count;
    logic                code_bit;
    logic                out_free;
  } opbe_status_t;

endpackage

// ----- rtl/core/opbe_ctrl.sv -----
// Sequencer: accepts items, runs the product pass and steps through the pulses of a frame.
module opbe_ctrl import opbe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic         action,
  input  opbe_status_t status,
  output opbe_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]          state, state_next;
  logic [PROD_W-1:0]   prep_cnt, prep_cnt_next;
  logic [BITCNT_W-1:0] bit_left, bit_left_next;
  logic                high, high_next;
  logic                sync, sync_next;
  logic                accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next    = state;
    prep_cnt_next = prep_cnt;
    bit_left_next = bit_left;
    high_next     = high;
    sync_next     = sync;
    cmd           = '0;
    cmd.prep_idx  = prep_cnt;
    cmd.bit_left  = bit_left;
    cmd.sync      = sync;
    cmd.high      = high;
    cmd.last      = sync && !high;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action == ACTION_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load      = 1'b1;
            prep_cnt_next = '0;
            bit_left_next = status.sat_count;
            sync_next     = (status.sat_count == '0);
            high_next     = 1'b1;
            state_next    = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        cmd.prep_en   = 1'b1;
        prep_cnt_next = prep_cnt + 1'b1;
        if (prep_cnt == PROD_W'(NUM_PROD - 1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (!sync) begin
            if (high) begin
              high_next = 1'b0;
            end else begin
              high_next     = 1'b1;
              bit_left_next = bit_left - 1'b1;
              if (bit_left == BITCNT_W'(1)) begin
                sync_next = 1'b1;
              end
            end
          end else if (high) begin
            high_next = 1'b0;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      prep_cnt <= '0;
      bit_left <= '0;
      high     <= 1'b1;
      sync     <= 1'b0;
    end else begin
      state    <= state_next;
      prep_cnt <= prep_cnt_next;
      bit_left <= bit_left_next;
      high     <= high_next;
      sync     <= sync_next;
    end
  end

endmodule

// ----- rtl/core/opbe_datapath.sv -----
// Datapath: configuration, pulse products, duration table lookup and result register.
module opbe_datapath import opbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  opbe_cmd_t             cmd,
  output opbe_status_t          status,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic [M_TUSER_W-1:0]  m_tuser,
  output logic                  m_tlast
);

  logic [UNIT_W-1:0]   pulse_unit;
  logic [FACTOR_W-1:0] sync_high_factor, sync_low_factor;
  logic [FACTOR_W-1:0] zero_high_factor, zero_low_factor;
  logic [FACTOR_W-1:0] one_high_factor, one_low_factor;

  logic [CODE_W-1:0]   code_q;
  logic [DUR_W-1:0]    prod_q [NUM_PROD];
  logic [DUR_W-1:0]    dur_table [TABLE_DEPTH];
  logic [CNT_W-1:0]    entry_count;

  logic [FACTOR_W-1:0] factor;
  logic [DUR_W-1:0]    product;
  logic [CODE_W-1:0]   code_shift;
  logic [BITCNT_W-1:0] in_count;
  logic [PROD_W-1:0]   sel;
  logic [DUR_W-1:0]    dur;
  logic [TABLE_DEPTH-1:0] hit;
  logic                found;
  logic                full;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    out_idx;

  logic [IDX_W-1:0]    idx_q;
  logic [DUR_W-1:0]    dur_q;
  logic                high_q, new_q, over_q, last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_unit       <= RST_PULSE_UNIT;
      sync_high_factor <= RST_SYNC_HIGH;
      sync_low_factor  <= RST_SYNC_LOW;
      zero_high_factor <= RST_ZERO_HIGH;
      zero_low_factor  <= RST_ZERO_LOW;
      one_high_factor  <= RST_ONE_HIGH;
      one_low_factor   <= RST_ONE_LOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PULSE_UNIT: pulse_unit       <= cfg_data[UNIT_W-1:0];
        REG_SYNC_HIGH:  sync_high_factor <= cfg_data[FACTOR_W-1:0];
        REG_SYNC_LOW:   sync_low_factor  <= cfg_data[FACTOR_W-1:0];
        REG_ZERO_HIGH:  zero_high_factor <= cfg_data[FACTOR_W-1:0];
        REG_ZERO_LOW:   zero_low_factor  <= cfg_data[FACTOR_W-1:0];
        REG_ONE_HIGH:   one_high_factor  <= cfg_data[FACTOR_W-1:0];
        REG_ONE_LOW:    one_low_factor   <= cfg_data[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_count = s_tdata[CODE_W +: BITCNT_W];
  assign status.sat_count = (in_count > BITCNT_W'(MAX_CODE_BITS)) ?
                            BITCNT_W'(MAX_CODE_BITS) : in_count;
  assign code_shift = code_q >> (cmd.bit_left - 1'b1);
  assign status.code_bit = code_shift[0];
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_q <= s_tdata[CODE_W-1:0];
    end
  end

  always_comb begin
    unique case (cmd.prep_idx)
      PROD_SYNC_HIGH: factor = sync_high_factor;
      PROD_SYNC_LOW:  factor = sync_low_factor;
      PROD_ZERO_HIGH: factor = zero_high_factor;
      PROD_ZERO_LOW:  factor = zero_low_factor;
      PROD_ONE_HIGH:  factor = one_high_factor;
      PROD_ONE_LOW:   factor = one_low_factor;
      default:        factor = '0;
    endcase
  end

  assign product = {{(DUR_W-UNIT_W){1'b0}}, pulse_unit} *
                   {{(DUR_W-FACTOR_W){1'b0}}, factor};

  always_ff @(posedge clk) begin
    if (cmd.prep_en) begin
      prod_q[cmd.prep_idx] <= product;
    end
  end

  always_comb begin
    if (cmd.sync) begin
      sel = cmd.high ? PROD_SYNC_HIGH : PROD_SYNC_LOW;
    end else if (status.code_bit) begin
      sel = cmd.high ? PROD_ONE_HIGH : PROD_ONE_LOW;
    end else begin
      sel = cmd.high ? PROD_ZERO_HIGH : PROD_ZERO_LOW;
    end
  end

  assign dur = prod_q[sel];

  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      hit[k] = (CNT_W'(k) < entry_count) && (dur_table[k] == dur);
    end
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (hit[k]) begin
        hit_idx = IDX_W'(k);
      end
    end
  end

  assign found = |hit;
  assign full  = (entry_count == CNT_W'(TABLE_DEPTH));

  always_comb begin
    priority if (found) begin
      out_idx = hit_idx;
    end else if (!full) begin
      out_idx = entry_count[IDX_W-1:0];
    end else begin
      out_idx = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && !found && !full) begin
      dur_table[entry_count[IDX_W-1:0]] <= dur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.clear) begin
      entry_count <= '0;
    end else if (cmd.emit && !found && !full) begin
      entry_count <= entry_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      idx_q  <= out_idx;
      dur_q  <= dur;
      high_q <= cmd.high;
      new_q  <= !found && !full;
      over_q <= !found && full;
      last_q <= cmd.last;
    end
  end

  assign m_tdata = {{(M_TDATA_W-IDX_W-DUR_W){1'b0}}, dur_q, idx_q};
  assign m_tuser = {over_q, new_q, high_q};
  assign m_tlast = last_q;

endmodule

// ----- rtl/core/ook_pulse_bucket_encoder_top.sv -----
// Top level of the OOK pulse bucket encoder: sequencer plus datapath.
//
// Input stream (s_*): one transaction is a send or a clear item; s_tuser is
// the action (0 send, 1 clear). A send walks the lowest bit_count bits of
// code_bits from the most significant down, one high and one low pulse per
// bit, then a sync high and a sync low pulse.
// Output stream (m_*): one transaction per pulse, in time order, carrying
// the duration, its table index and flags; m_tlast marks the sync low pulse.
// Config port: cfg_we writes cfg_data into register cfg_index at once; write
// only while no frame is in flight.
// Sequence: a send is accepted, then a product pass computes the six pulse
// products on one multiplier, then the pulses are issued. Pulses leave one
// per cycle while m_tready does not stall them; a send holds off the input
// until its last pulse is issued, while a clear leaves it ready.
// The table lookup compares all filled entries in parallel in the pulse cycle.
// A stalled m_tready holds the result register and the pulse stepping; s_tready
// is high only between frames. Reset restores the register defaults, empties
// the duration table and drops any pending result.
module ook_pulse_bucket_encoder_top import opbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // code_bits[30:0], bit_count[35:31], zeros
  input  logic                  s_tuser,   // action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // bucket_index[3:0], pulse_duration[26:4], zeros
  output logic [M_TUSER_W-1:0]  m_tuser,   // level_high, new_entry, table_overflow
  output logic                  m_tlast    // last_pulse
);

  opbe_cmd_t    cmd;
  opbe_status_t status;

  opbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .action   (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  opbe_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- rtl/core/opbe_checker.sv -----
// Port-level checker of the pulse bucket encoder, bound to the top level.
`include "ook_pulse_bucket_encoder_top_defines.svh"

module opbe_checker import opbe_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_TDATA_W-1:0]  m_tdata,
  input logic [M_TUSER_W-1:0]  m_tuser,
  input logic                  m_tlast
);

  `OPBE_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
    "result changed under stall")
  `OPBE_ASSERT_NOW(a_overflow_index, m_tvalid && m_tuser[2],
    m_tdata[3:0] == 4'd0 && !m_tuser[1], "overflow pulse with index or new entry")
  `OPBE_ASSERT_NOW(a_last_is_low, m_tvalid && m_tlast, !m_tuser[0],
    "frame end on a high pulse")
  `OPBE_ASSERT_NEXT(a_frame_continues, m_tvalid && m_tready && !m_tlast, m_tvalid,
    "frame stopped before its last pulse")
  `OPBE_ASSERT_NEXT(a_send_busy, s_tvalid && s_tready && s_tuser == ACTION_SEND,
    !s_tready, "input ready right after a send")

endmodule

bind ook_pulse_bucket_encoder_top opbe_checker u_opbe_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the OOK pulse bucket encoder: directed and random traffic.
`timescale 1ns / 1ps

module tb_top;
  import opbe_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [IDX_W-1:0] bucket;
    logic [DUR_W-1:0] dur;
    logic             high;
    logic             fresh;
    logic             over;
    logic             last;
  } pulse_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  m_tlast;

  pulse_t pulse_q[$];
  pulse_t want;
  pulse_t got;

  logic [UNIT_W-1:0]     unit_r;
  logic [FACTOR_W-1:0]   fac_r[8];
  logic [DUR_W-1:0]      dur_tab[TABLE_DEPTH];
  int                    n_entries;
  logic [CFG_DATA_W-1:0] cfg_plan[8];

  bit s_idle;
  bit m_idle;
  int err_count;
  int quiet_cycles;

  ook_pulse_bucket_encoder_top u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // mirror of the register file
  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_PULSE_UNIT) begin
      unit_r = data[UNIT_W-1:0];
    end else if (idx <= REG_ONE_LOW) begin
      fac_r[idx] = data[FACTOR_W-1:0];
    end
  endtask

  task automatic bucket_pulse(input logic [FACTOR_W-1:0] factor, input bit high, input bit last);
    logic [DUR_W-1:0] d;
    pulse_t p;
    bit hit;
    d = unit_r * factor;
    p = '0;
    hit = 0;
    for (int k = 0; k < n_entries; k++) begin
      if (!hit && dur_tab[k] == d) begin
        hit = 1;
        p.bucket = k[IDX_W-1:0];
      end
    end
    if (!hit) begin
      if (n_entries < TABLE_DEPTH) begin
        p.bucket = n_entries[IDX_W-1:0];
        dur_tab[n_entries] = d;
        n_entries++;
        p.fresh = 1'b1;
      end else begin
        p.over = 1'b1;
      end
    end
    p.dur = d;
    p.high = high;
    p.last = last;
    pulse_q.insert(pulse_q.size(), p);
  endtask

  task automatic encode_frame(input logic action, input logic [CODE_W-1:0] code,
                              input logic [BITCNT_W-1:0] count);
    int nbits;
    if (action == ACTION_CLEAR) begin
      n_entries = 0;
      return;
    end
    nbits = (count > MAX_CODE_BITS) ? MAX_CODE_BITS : count;
    for (int i = nbits; i > 0; i--) begin
      if (code[i-1]) begin
        bucket_pulse(fac_r[REG_ONE_HIGH], 1, 0);
        bucket_pulse(fac_r[REG_ONE_LOW], 0, 0);
      end else begin
        bucket_pulse(fac_r[REG_ZERO_HIGH], 1, 0);
        bucket_pulse(fac_r[REG_ZERO_LOW], 0, 0);
      end
    end
    bucket_pulse(fac_r[REG_SYNC_HIGH], 1, 0);
    bucket_pulse(fac_r[REG_SYNC_LOW], 0, 1);
  endtask

  task automatic send_item(input logic action, input logic [CODE_W-1:0] code,
                           input logic [BITCNT_W-1:0] count);
    int gap;
    gap = s_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {4'b0, count, code};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    encode_frame(action, code, count);
  endtask

  // hold off until every pulse is out, then let a clear finish
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pulse_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic program_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= cfg_plan[i];
      @(posedge clk);
      apply_reg(CFG_IDX_W'(i), cfg_plan[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic plan_regs(input logic [15:0] unit, input int sh, input int sl, input int zh,
                           input int zl, input int oh, input int ol);
    cfg_plan[REG_PULSE_UNIT] = unit;
    cfg_plan[REG_SYNC_HIGH]  = 16'(sh);
    cfg_plan[REG_SYNC_LOW]   = 16'(sl);
    cfg_plan[REG_ZERO_HIGH]  = 16'(zh);
    cfg_plan[REG_ZERO_LOW]   = 16'(zl);
    cfg_plan[REG_ONE_HIGH]   = 16'(oh);
    cfg_plan[REG_ONE_LOW]    = 16'(ol);
    cfg_plan[7]              = 16'($urandom);
  endtask

  task automatic test_defaults();
    s_idle = 1;
    m_idle = 0;
    send_item(ACTION_SEND, 31'h0, 5'd0);
    send_item(ACTION_SEND, 31'h5, 5'd3);
    m_idle = 1;
    send_item(ACTION_SEND, 31'h2AAAAAAA, 5'd31);
  endtask

  task automatic test_word_extremes();
    send_item(ACTION_SEND, 31'h7FFFFFFF, 5'd31);
    send_item(ACTION_SEND, 31'h0, 5'd31);
    send_item(ACTION_SEND, 31'h7FFFFFFF, 5'd0);
    send_item(ACTION_CLEAR, 31'h7FFFFFFF, 5'd31);
    send_item(ACTION_SEND, 31'h1, 5'd1);
  endtask

  task automatic test_table_full();
    wait_idle();
    send_item(ACTION_CLEAR, 31'h0, 5'd0);
    wait_idle();
    plan_regs(16'd1, 1, 2, 3, 4, 5, 6);
    program_regs();
    send_item(ACTION_SEND, 31'hA, 5'd4);
    wait_idle();
    plan_regs(16'd1, 7, 8, 9, 10, 11, 12);
    program_regs();
    send_item(ACTION_SEND, 31'hA, 5'd4);
    wait_idle();
    plan_regs(16'd1, 13, 14, 15, 16, 17, 18);
    program_regs();
    send_item(ACTION_SEND, 31'hA, 5'd4);
    send_item(ACTION_SEND, 31'h3, 5'd2);
    send_item(ACTION_CLEAR, 31'h0, 5'd0);
    send_item(ACTION_SEND, 31'h6, 5'd3);
  endtask

  task automatic test_unit_factor_extremes();
    wait_idle();
    plan_regs(16'hFFFF, 16'hFF80 | 127, 127, 127, 127, 127, 127);
    program_regs();
    send_item(ACTION_SEND, 31'h55, 5'd8);
    wait_idle();
    plan_regs(16'h0000, 127, 1, 5, 64, 0, 3);
    program_regs();
    send_item(ACTION_SEND, 31'h3C, 5'd6);
    wait_idle();
    plan_regs(16'hFFFF, 0, 0, 0, 0, 0, 0);
    program_regs();
    send_item(ACTION_SEND, 31'h2, 5'd2);
    wait_idle();
    plan_regs(16'd1, 16'hFFFF, 16'h0080, 1, 0, 127, 64);
    program_regs();
    send_item(ACTION_SEND, 31'h1, 5'd2);
  endtask

  task automatic test_random_traffic();
    int mode;
    int r;
    logic [BITCNT_W-1:0] cnt;
    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      mode = $urandom_range(0, 2);
      cfg_plan[REG_PULSE_UNIT] = (mode == 2) ? (($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1)
                                            : 16'($urandom);
      for (int i = 1; i < 8; i++) begin
        case (mode)
          0: cfg_plan[i] = {9'($urandom), 7'($urandom_range(0, 3))};
          1: cfg_plan[i] = 16'($urandom);
          default: cfg_plan[i] = {9'($urandom), ($urandom_range(0, 1) != 0) ? 7'd127 : 7'd0};
        endcase
      end
      program_regs();
      s_idle = ($urandom_range(0, 3) != 0);
      m_idle = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 25; n++) begin
        r = $urandom_range(0, 99);
        cnt = (r < 15) ? 5'd31 : 5'($urandom_range(0, 31));
        if (r >= 90) begin
          send_item(ACTION_CLEAR, 31'($urandom), 5'($urandom));
        end else begin
          send_item(ACTION_SEND, 31'($urandom), cnt);
        end
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = ACTION_SEND;
    err_count = 0;
    n_entries = 0;
    s_idle    = 0;
    m_idle    = 0;
    unit_r    = RST_PULSE_UNIT;
    fac_r[REG_SYNC_HIGH] = RST_SYNC_HIGH;
    fac_r[REG_SYNC_LOW]  = RST_SYNC_LOW;
    fac_r[REG_ZERO_HIGH] = RST_ZERO_HIGH;
    fac_r[REG_ZERO_LOW]  = RST_ZERO_LOW;
    fac_r[REG_ONE_HIGH]  = RST_ONE_HIGH;
    fac_r[REG_ONE_LOW]   = RST_ONE_LOW;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_word_extremes();
    test_table_full();
    test_unit_factor_extremes();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // receiver: random stall before each transaction while m_idle is set
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      gap = m_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic check_field(input string name, input logic [DUR_W-1:0] exp_v,
                             input logic [DUR_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.bucket = m_tdata[3:0];
      got.dur    = m_tdata[26:4];
      got.high   = m_tuser[0];
      got.fresh  = m_tuser[1];
      got.over   = m_tuser[2];
      got.last   = m_tlast;
      if (pulse_q.size() == 0) begin
        $display("%0t: pulse expected none actual dur %0d idx %0d", $time, got.dur, got.bucket);
        err_count++;
      end else begin
        want = pulse_q.pop_front();
        check_field("bucket_index", want.bucket, got.bucket);
        check_field("pulse_duration", want.dur, got.dur);
        check_field("level_high", want.high, got.high);
        check_field("new_entry", want.fresh, got.fresh);
        check_field("table_overflow", want.over, got.over);
        check_field("last_pulse", want.last, got.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

endmodule
